// File: design/pose_prediction_with_jacobian_macros.svh
`ifndef POSE_PREDICTION_WITH_JACOBIAN_MACROS_SVH
`define POSE_PREDICTION_WITH_JACOBIAN_MACROS_SVH

// Implication in the same cycle, off during reset.
`define PPJ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication into the next cycle, off during reset.
`define PPJ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Property that holds at every edge, reset included.
`define PPJ_ASSERT_ALW(lbl, clk, expr) \
	lbl: assert property (@(posedge clk) (expr)) else $error("assertion failed");

`endif

// File: design/ppj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppj_pkg;

	// Field widths.
	localparam int POS_W = 32;
	localparam int ANG_W = 16;
	localparam int IN16_W = 16;

	// Internal widths.
	localparam int D_W = 33;               // speed * step_time, Q8.24
	localparam int CW = 34;                // CORDIC datapath
	localparam int TRIG_W = 20;            // sine and cosine, Q16
	localparam int P1_W = D_W + TRIG_W;    // first product
	localparam int DC_W = 38;              // d*cos(pitch), d*sin(pitch), Q24
	localparam int P2_W = DC_W + TRIG_W;   // second product
	localparam int M_W = 42;               // second product rounded to Q24
	localparam int SAT_W = 40;             // width ahead of saturation

	localparam int CORDIC_STEPS = 20;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
		34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
		34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
		34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304
	};

	// Pose and step data carried down the pipeline.
	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic [ANG_W-1:0] roll;
		logic [ANG_W-1:0] pitch;
		logic [ANG_W-1:0] yaw;
		logic signed [D_W-1:0] d;
		logic [ANG_W-1:0] dyaw;
	} pay_t;

	// Clamp to the signed 32-bit range.
	function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(signed'(32'h7FFF_FFFF));
		lo = SAT_W'(signed'(32'h8000_0000));
		if (v > hi) return 32'h7FFF_FFFF;
		if (v < lo) return 32'h8000_0000;
		return v[POS_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: design/ppj_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppj_in_if;
	import ppj_pkg::*;
	logic valid;
	logic ready;
	logic signed [POS_W-1:0] pos_x_in;
	logic signed [POS_W-1:0] pos_y_in;
	logic signed [POS_W-1:0] pos_z_in;
	logic [ANG_W-1:0] roll_in;
	logic [ANG_W-1:0] pitch_in;
	logic [ANG_W-1:0] yaw_in;
	logic signed [IN16_W-1:0] speed;
	logic signed [IN16_W-1:0] yaw_rate;
	logic [IN16_W-1:0] step_time;

	modport source (output valid, pos_x_in, pos_y_in, pos_z_in, roll_in, pitch_in, yaw_in,
		speed, yaw_rate, step_time, input ready);
	modport sink (input valid, pos_x_in, pos_y_in, pos_z_in, roll_in, pitch_in, yaw_in,
		speed, yaw_rate, step_time, output ready);
endinterface
`default_nettype wire

// File: design/ppj_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppj_out_if;
	import ppj_pkg::*;
	logic valid;
	logic ready;
	logic signed [POS_W-1:0] pos_x_out;
	logic signed [POS_W-1:0] pos_y_out;
	logic signed [POS_W-1:0] pos_z_out;
	logic [ANG_W-1:0] roll_out;
	logic [ANG_W-1:0] pitch_out;
	logic [ANG_W-1:0] yaw_out;
	logic signed [POS_W-1:0] jac_x_pitch;
	logic signed [POS_W-1:0] jac_x_yaw;
	logic signed [POS_W-1:0] jac_y_pitch;
	logic signed [POS_W-1:0] jac_y_yaw;
	logic signed [POS_W-1:0] jac_z_pitch;

	modport source (output valid, pos_x_out, pos_y_out, pos_z_out, roll_out, pitch_out,
		yaw_out, jac_x_pitch, jac_x_yaw, jac_y_pitch, jac_y_yaw, jac_z_pitch, input ready);
	modport sink (input valid, pos_x_out, pos_y_out, pos_z_out, roll_out, pitch_out,
		yaw_out, jac_x_pitch, jac_x_yaw, jac_y_pitch, jac_y_yaw, jac_z_pitch, output ready);
endinterface
`default_nettype wire

// File: design/ppj_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined sine and cosine: one rotation per stage, then a rounding stage.
module ppj_cordic import ppj_pkg::*; (
	input  wire logic clk,
	input  wire logic [CORDIC_STEPS:0] en,
	input  wire logic [ANG_W-1:0] ang,
	output logic signed [TRIG_W-1:0] sin_q16,
	output logic signed [TRIG_W-1:0] cos_q16
);

	logic signed [CW-1:0] x_s [CORDIC_STEPS];
	logic signed [CW-1:0] y_s [CORDIC_STEPS];
	logic signed [CW-1:0] t_s [CORDIC_STEPS];
	logic flip_s [CORDIC_STEPS];

	logic signed [CW-1:0] t0;
	logic flip0;
	logic signed [CW-1:0] xf;
	logic signed [CW-1:0] yf;

	// Fold the angle into the right half plane by a half-turn move.
	always_comb begin
		logic signed [CW-1:0] ta;
		ta = CW'(signed'({ang, 16'h0000}));
		t0 = ta;
		flip0 = 1'b0;
		if (ta > CW'(signed'(32'h4000_0000))) begin
			t0 = ta - CW'(35'sh0_8000_0000);
			flip0 = 1'b1;
		end else if (ta < -CW'(signed'(32'h4000_0000))) begin
			t0 = ta + CW'(35'sh0_8000_0000);
			flip0 = 1'b1;
		end
	end

	// Rotation stages.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] ti;
		logic fi;
		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign ti = t0;
			assign fi = flip0;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign ti = t_s[i-1];
			assign fi = flip_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (!ti[CW-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					t_s[i] <= ti - ATAN_TAB[i];
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					t_s[i] <= ti + ATAN_TAB[i];
				end
				flip_s[i] <= fi;
			end
		end
	end

	// Undo the fold and round from Q30 to Q16.
	assign xf = flip_s[CORDIC_STEPS-1] ? -x_s[CORDIC_STEPS-1] : x_s[CORDIC_STEPS-1];
	assign yf = flip_s[CORDIC_STEPS-1] ? -y_s[CORDIC_STEPS-1] : y_s[CORDIC_STEPS-1];

	always_ff @(posedge clk) begin
		if (en[CORDIC_STEPS]) begin
			cos_q16 <= TRIG_W'((xf + CW'(signed'(15'sd8192))) >>> 14);
			sin_q16 <= TRIG_W'((yf + CW'(signed'(15'sd8192))) >>> 14);
		end
	end

endmodule
`default_nettype wire

// File: design/pose_prediction_with_jacobian.sv
`timescale 1ns / 1ps
`default_nettype none
// Dead-reckoning pose prediction with its motion Jacobian. A pose word is
// accepted every cycle unless the pipeline has backed up behind a stalled
// output, and its result word passes through capture, the two 20-stage CORDIC
// pipelines (yaw and pitch), rounding, two multiplier stages and the output
// register. Each stage holds its word independently, so bubbles close up and
// new words are taken while a finished word waits at the output.
module pose_prediction_with_jacobian import ppj_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ppj_in_if.sink pose_in,
	ppj_out_if.source pose_out
);

	localparam int NSTG = CORDIC_STEPS + 5;
	localparam int TRIG_STG = CORDIC_STEPS + 2;

	logic [NSTG:1] vld_s;
	logic [NSTG+1:1] adv;

	pay_t pl_s [1:TRIG_STG];

	logic signed [TRIG_W-1:0] sy, cy, sp, cp;

	// Stage advance: a stage moves when it is empty or the next one moves.
	always_comb begin
		adv[NSTG+1] = pose_out.ready;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign pose_in.ready = adv[1];
	assign pose_out.valid = vld_s[NSTG];

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) vld_s[1] <= pose_in.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Stage 1: capture and form the distance and the yaw increment.
	// Pose data then rides alongside the CORDIC stages.
	always_ff @(posedge clk) begin
		logic signed [D_W-1:0] wdt;
		wdt = D_W'(pose_in.yaw_rate) * D_W'(signed'({1'b0, pose_in.step_time}));
		if (adv[1]) begin
			pl_s[1].px <= pose_in.pos_x_in;
			pl_s[1].py <= pose_in.pos_y_in;
			pl_s[1].pz <= pose_in.pos_z_in;
			pl_s[1].roll <= pose_in.roll_in;
			pl_s[1].pitch <= pose_in.pitch_in;
			pl_s[1].yaw <= pose_in.yaw_in;
			pl_s[1].d <= D_W'(pose_in.speed) * D_W'(signed'({1'b0, pose_in.step_time}));
			pl_s[1].dyaw <= ANG_W'((wdt + D_W'(signed'(17'sd32768))) >>> 16);
		end
		for (int k = 2; k <= TRIG_STG; k++) begin
			if (adv[k]) pl_s[k] <= pl_s[k-1];
		end
	end

	ppj_cordic u_yaw (
		.clk(clk), .en(adv[TRIG_STG:2]), .ang(pl_s[1].yaw), .sin_q16(sy), .cos_q16(cy)
	);

	ppj_cordic u_pitch (
		.clk(clk), .en(adv[TRIG_STG:2]), .ang(pl_s[1].pitch), .sin_q16(sp), .cos_q16(cp)
	);

	// Stage 23: distance times cos and sin of pitch, rounded to Q24.
	logic signed [DC_W-1:0] dcp_s23, dsp_s23;
	logic signed [TRIG_W-1:0] sy_s23, cy_s23;
	logic signed [POS_W-1:0] px_s23, py_s23, pz_s23;
	logic [ANG_W-1:0] roll_s23, pitch_s23, yaw_s23;

	always_ff @(posedge clk) begin
		logic signed [P1_W-1:0] pc;
		logic signed [P1_W-1:0] ps;
		pc = P1_W'(pl_s[TRIG_STG].d) * P1_W'(cp);
		ps = P1_W'(pl_s[TRIG_STG].d) * P1_W'(sp);
		if (adv[TRIG_STG+1]) begin
			dcp_s23 <= DC_W'((pc + P1_W'(signed'(17'sd32768))) >>> 16);
			dsp_s23 <= DC_W'((ps + P1_W'(signed'(17'sd32768))) >>> 16);
			sy_s23 <= sy;
			cy_s23 <= cy;
			px_s23 <= pl_s[TRIG_STG].px;
			py_s23 <= pl_s[TRIG_STG].py;
			pz_s23 <= pl_s[TRIG_STG].pz;
			roll_s23 <= pl_s[TRIG_STG].roll;
			pitch_s23 <= pl_s[TRIG_STG].pitch;
			yaw_s23 <= pl_s[TRIG_STG].yaw + pl_s[TRIG_STG].dyaw;
		end
	end

	// Stage 24: products with cos and sin of yaw, plus the z terms.
	logic signed [M_W-1:0] mxc_s24, mxs_s24, msc_s24, mss_s24;
	logic signed [DC_W-1:0] zr_s24, jz_s24;
	logic signed [POS_W-1:0] px_s24, py_s24, pz_s24;
	logic [ANG_W-1:0] roll_s24, pitch_s24, yaw_s24;

	always_ff @(posedge clk) begin
		logic signed [P2_W-1:0] a, b, c, e;
		logic signed [P2_W-1:0] r16;
		logic signed [DC_W-1:0] r8;
		r16 = P2_W'(signed'(17'sd32768));
		r8 = DC_W'(signed'(9'sd128));
		a = P2_W'(dcp_s23) * P2_W'(cy_s23);
		b = P2_W'(dcp_s23) * P2_W'(sy_s23);
		c = P2_W'(dsp_s23) * P2_W'(cy_s23);
		e = P2_W'(dsp_s23) * P2_W'(sy_s23);
		if (adv[TRIG_STG+2]) begin
			mxc_s24 <= M_W'((a + r16) >>> 16);
			mxs_s24 <= M_W'((b + r16) >>> 16);
			msc_s24 <= M_W'((c + r16) >>> 16);
			mss_s24 <= M_W'((e + r16) >>> 16);
			zr_s24 <= (dsp_s23 + r8) >>> 8;
			jz_s24 <= -((dcp_s23 + r8) >>> 8);
			px_s24 <= px_s23;
			py_s24 <= py_s23;
			pz_s24 <= pz_s23;
			roll_s24 <= roll_s23;
			pitch_s24 <= pitch_s23;
			yaw_s24 <= yaw_s23;
		end
	end

	// Stage 25: round to Q16, add to the position, saturate.
	logic signed [POS_W-1:0] px_s25, py_s25, pz_s25, jxp_s25, jxy_s25, jyp_s25, jyy_s25;
	logic signed [POS_W-1:0] jzp_s25;
	logic [ANG_W-1:0] roll_s25, pitch_s25, yaw_s25;

	always_ff @(posedge clk) begin
		logic signed [M_W-1:0] r8m;
		logic signed [M_W-1:0] dx, dy, rxp, ryp;
		logic signed [SAT_W-1:0] dxe, dye, rxpe, rype;
		r8m = M_W'(signed'(9'sd128));
		dx = (mxc_s24 + r8m) >>> 8;
		dy = (mxs_s24 + r8m) >>> 8;
		rxp = (msc_s24 + r8m) >>> 8;
		ryp = (mss_s24 + r8m) >>> 8;
		dxe = dx[SAT_W-1:0];
		dye = dy[SAT_W-1:0];
		rxpe = rxp[SAT_W-1:0];
		rype = ryp[SAT_W-1:0];
		if (adv[NSTG]) begin
			px_s25 <= sat32(SAT_W'(px_s24) + dxe);
			py_s25 <= sat32(SAT_W'(py_s24) + dye);
			pz_s25 <= sat32(SAT_W'(pz_s24) - SAT_W'(zr_s24));
			jxp_s25 <= sat32(-rxpe);
			jxy_s25 <= sat32(-dye);
			jyp_s25 <= sat32(-rype);
			jyy_s25 <= sat32(dxe);
			jzp_s25 <= sat32(SAT_W'(jz_s24));
			roll_s25 <= roll_s24;
			pitch_s25 <= pitch_s24;
			yaw_s25 <= yaw_s24;
		end
	end

	assign pose_out.pos_x_out = px_s25;
	assign pose_out.pos_y_out = py_s25;
	assign pose_out.pos_z_out = pz_s25;
	assign pose_out.roll_out = roll_s25;
	assign pose_out.pitch_out = pitch_s25;
	assign pose_out.yaw_out = yaw_s25;
	assign pose_out.jac_x_pitch = jxp_s25;
	assign pose_out.jac_x_yaw = jxy_s25;
	assign pose_out.jac_y_pitch = jyp_s25;
	assign pose_out.jac_y_yaw = jyy_s25;
	assign pose_out.jac_z_pitch = jzp_s25;

endmodule
`default_nettype wire

// File: design/ppj_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pose_prediction_with_jacobian_macros.svh"
// Port-level checks on the pose pipeline.
module ppj_checker import ppj_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [POS_W-1:0] out_x,
	input wire logic [ANG_W-1:0] out_yaw,
	input wire logic [POS_W-1:0] out_jzp
);

	// A stalled result word stays and holds its value.
	`PPJ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`PPJ_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_x) && $stable(out_yaw) && $stable(out_jzp))

	// Input is refused only while the whole pipeline backs up behind a stalled output.
	`PPJ_ASSERT_IMP(a_ready_stall, clk, arst_n, !in_ready, out_valid && !out_ready)

	// No result word shows while reset is held.
	`PPJ_ASSERT_ALW(a_reset_empty, clk, arst_n || !out_valid)

endmodule

bind pose_prediction_with_jacobian ppj_checker u_ppj_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(pose_in.ready),
	.out_valid(pose_out.valid),
	.out_ready(pose_out.ready),
	.out_x(pose_out.pos_x_out),
	.out_yaw(pose_out.yaw_out),
	.out_jzp(pose_out.jac_z_pitch)
);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ppj_pkg::*;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic [15:0] roll, pitch, yaw;
		logic signed [15:0] speed, yaw_rate;
		logic [15:0] step_time;
	} pose_word_t;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic [15:0] roll, pitch, yaw;
		logic signed [31:0] jxp, jxy, jyp, jyy, jzp;
	} pred_word_t;

	// One row of the directed table; a known result is checked as typed in.
	typedef struct {
		pose_word_t pose;
		bit known;
		pred_word_t res;
	} stim_row_t;

	localparam int ITEMS = 900;
	localparam int LATENCY = 25;
	localparam int NDIR = 14;

	logic clk = 1'b0;
	logic arst_n;
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 1'b0;
	pred_word_t expected_q[$];
	stim_row_t rows[NDIR];

	ppj_in_if pose_in();
	ppj_out_if pose_out();

	pose_prediction_with_jacobian dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose_in(pose_in.sink),
		.pose_out(pose_out.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rounding helpers: floor shift and nearest with ties upward.
	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rshr(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Sine and cosine of a binary angle in Q16 by rotation-mode CORDIC.
	function automatic void sincos(logic [15:0] ang, output longint s, output longint c);
		longint t, x, y, dx, dy;
		bit flip;
		t = longint'(signed'({ang, 16'h0000}));
		flip = 1'b0;
		x = 64'sd652032874;
		y = 0;
		if (t > (longint'(1) << 30)) begin
			t -= longint'(1) << 31;
			flip = 1'b1;
		end else if (t < -(longint'(1) << 30)) begin
			t += longint'(1) << 31;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (t >= 0) begin
				x -= dx;
				y += dy;
				t -= longint'(ATAN_TAB[i]);
			end else begin
				x += dx;
				y -= dy;
				t += longint'(ATAN_TAB[i]);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = rshr(x, 14);
		s = rshr(y, 14);
	endfunction

	// Predicted pose and Jacobian entries for one pose word.
	function automatic pred_word_t predict_pose(pose_word_t p);
		pred_word_t r;
		longint sy, cy, sp, cp, d, dcp, dsp, dx, dy, dz, dyaw;
		sincos(p.yaw, sy, cy);
		sincos(p.pitch, sp, cp);
		d = longint'(p.speed) * longint'({1'b0, p.step_time});
		dcp = rshr(d * cp, 16);
		dsp = rshr(d * sp, 16);
		dx = rshr(rshr(dcp * cy, 16), 8);
		dy = rshr(rshr(dcp * sy, 16), 8);
		dz = rshr(dsp, 8);
		r.px = clamp32(longint'(p.px) + dx);
		r.py = clamp32(longint'(p.py) + dy);
		r.pz = clamp32(longint'(p.pz) - dz);
		r.roll = p.roll;
		r.pitch = p.pitch;
		dyaw = rshr(longint'(p.yaw_rate) * longint'({1'b0, p.step_time}), 16);
		r.yaw = p.yaw + dyaw[15:0];
		r.jxp = clamp32(-rshr(rshr(dsp * cy, 16), 8));
		r.jxy = clamp32(-dy);
		r.jyp = clamp32(-rshr(rshr(dsp * sy, 16), 8));
		r.jyy = clamp32(dx);
		r.jzp = clamp32(-rshr(dcp, 8));
		return r;
	endfunction

	function automatic pose_word_t random_pose(int mode);
		pose_word_t p;
		p.px = $urandom;
		p.py = $urandom;
		p.pz = $urandom;
		p.roll = $urandom;
		p.pitch = $urandom;
		p.yaw = $urandom;
		p.speed = $urandom;
		p.yaw_rate = $urandom;
		p.step_time = $urandom;
		// Positions near the rails to exercise saturation.
		if (mode == 1) begin
			p.px = $urandom_range(1) ? 32'h7FFF_0000 + $urandom_range(65535)
				: 32'h8000_0000 + $urandom_range(65535);
			p.pz = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end
		// Angles near the quarter-turn boundaries.
		if (mode == 2) begin
			p.pitch = 16'h4000 + $urandom_range(4) - 2;
			p.yaw = 16'hC000 + $urandom_range(4) - 2;
		end
		return p;
	endfunction

	function automatic pose_word_t mk_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw, logic [15:0] v,
			logic [15:0] w, logic [15:0] dt);
		pose_word_t p;
		p.px = px;
		p.py = py;
		p.pz = pz;
		p.roll = roll;
		p.pitch = pitch;
		p.yaw = yaw;
		p.speed = v;
		p.yaw_rate = w;
		p.step_time = dt;
		return p;
	endfunction

	// Zero step: pose passes through and every Jacobian entry is zero.
	function automatic pred_word_t still_pose(pose_word_t p);
		pred_word_t r;
		r.px = p.px;
		r.py = p.py;
		r.pz = p.pz;
		r.roll = p.roll;
		r.pitch = p.pitch;
		r.yaw = p.yaw;
		r.jxp = 0;
		r.jxy = 0;
		r.jyp = 0;
		r.jyy = 0;
		r.jzp = 0;
		return r;
	endfunction

	task automatic fill_table();
		rows[0].pose = mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0);
		rows[1].pose = mk_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF, 16'h7FFF, 0);
		rows[2].pose = mk_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			16'h5555, 16'hC000, 16'h4000, 0, 16'h8000, 16'hFFFF);
		rows[3].pose = mk_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			0, 0, 0, 16'h7FFF, 0, 16'hFFFF);
		rows[4].pose = mk_pose(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			0, 16'h4000, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
		rows[5].pose = mk_pose(1, 2, 3, 16'hAAAA, 16'h4000, 16'h4000, 16'h0100, 1, 16'h8000);
		rows[6].pose = mk_pose(0, 0, 0, 0, 16'hC000, 16'hC000, 16'hFF00, 16'hFFFF, 16'h8000);
		rows[7].pose = mk_pose(0, 0, 0, 0, 16'h4001, 16'hBFFF, 16'h0100, 16'h0001, 16'h0001);
		rows[8].pose = mk_pose(0, 0, 0, 0, 16'h8000, 16'h8001, 16'h0100, 16'h8000, 16'h0001);
		rows[9].pose = mk_pose(0, 0, 0, 0, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
		rows[10].pose = mk_pose(0, 0, 0, 0, 16'h2000, 16'h6000, 16'h0100, 0, 16'h0001);
		rows[11].pose = mk_pose(32'hFFFF_FFFF, 32'h0000_8000, 32'h1234_5678,
			16'h0001, 16'hE000, 16'hA000, 16'h0080, 16'h0002, 16'h8000);
		rows[12].pose = mk_pose(0, 0, 0, 0, 0, 16'hFFFF, 0, 16'h0001, 16'h8000);
		rows[13].pose = mk_pose(0, 0, 0, 0, 0, 16'hFFFF, 0, 16'hFFFF, 16'h8000);
		foreach (rows[i]) rows[i].known = 1'b0;
		rows[0].known = 1'b1;
		rows[0].res = still_pose(rows[0].pose);
		rows[1].known = 1'b1;
		rows[1].res = still_pose(rows[1].pose);
		// Yaw wraps up through zero on a tie rounded upward.
		rows[12].known = 1'b1;
		rows[12].res = still_pose(rows[12].pose);
		rows[12].res.yaw = 16'h0000;
		// A negative half-unit tie rounds up to zero.
		rows[13].known = 1'b1;
		rows[13].res = still_pose(rows[13].pose);
	endtask

	// Offer one word and hold it until the block takes it.
	task automatic send_pose(pose_word_t p, pred_word_t r);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			pose_in.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		pose_in.valid <= 1'b1;
		pose_in.pos_x_in <= p.px;
		pose_in.pos_y_in <= p.py;
		pose_in.pos_z_in <= p.pz;
		pose_in.roll_in <= p.roll;
		pose_in.pitch_in <= p.pitch;
		pose_in.yaw_in <= p.yaw;
		pose_in.speed <= p.speed;
		pose_in.yaw_rate <= p.yaw_rate;
		pose_in.step_time <= p.step_time;
		do @(posedge clk); while (!pose_in.ready);
		expected_q.push_back(r);
	endtask

	task automatic cmp(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// Output side: check each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		pred_word_t e;
		if (arst_n && pose_out.valid && pose_out.ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected", $time);
			end else begin
				e = expected_q.pop_front();
				cmp("pos_x_out", e.px, pose_out.pos_x_out);
				cmp("pos_y_out", e.py, pose_out.pos_y_out);
				cmp("pos_z_out", e.pz, pose_out.pos_z_out);
				cmp("roll_out", e.roll, pose_out.roll_out);
				cmp("pitch_out", e.pitch, pose_out.pitch_out);
				cmp("yaw_out", e.yaw, pose_out.yaw_out);
				cmp("jac_x_pitch", e.jxp, pose_out.jac_x_pitch);
				cmp("jac_x_yaw", e.jxy, pose_out.jac_x_yaw);
				cmp("jac_y_pitch", e.jyp, pose_out.jac_y_pitch);
				cmp("jac_y_yaw", e.jyy, pose_out.jac_y_yaw);
				cmp("jac_z_pitch", e.jzp, pose_out.jac_z_pitch);
			end
		end
	end

	// Receiver ready, stalled at random or held off for a long stretch.
	always @(posedge clk) begin
		pose_out.ready <= !hold_off && !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	// Long hold-off on the output while the sender keeps offering words.
	initial begin
		int held;
		wait (hold_off);
		held = 0;
		while (held < 80) begin
			@(posedge clk);
			held++;
		end
		hold_off = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		pose_word_t p;
		int drain;
		arst_n <= 1'b0;
		pose_in.valid = 1'b0;
		pose_in.pos_x_in = '0;
		pose_in.pos_y_in = '0;
		pose_in.pos_z_in = '0;
		pose_in.roll_in = '0;
		pose_in.pitch_in = '0;
		pose_in.yaw_in = '0;
		pose_in.speed = '0;
		pose_in.yaw_rate = '0;
		pose_in.step_time = '0;
		pose_out.ready = 1'b0;
		fill_table();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words.
		foreach (rows[i]) begin
			if (rows[i].known) send_pose(rows[i].pose, rows[i].res);
			else send_pose(rows[i].pose, predict_pose(rows[i].pose));
		end

		// Random words across the idling phases.
		for (int n = 0; n < ITEMS; n++) begin
			case (n / 150)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 77; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 77; end
				3: begin send_idle = 31; recv_stall = 31; end
				4: begin send_idle = 0; recv_stall = 0; end
				default: begin send_idle = $urandom_range(1) ? 31 : 0; recv_stall = 31; end
			endcase
			if (n == 620) hold_off = 1'b1;
			p = random_pose($urandom_range(9) == 0 ? 1 : ($urandom_range(9) == 0 ? 2 : 0));
			send_pose(p, predict_pose(p));
		end
		pose_in.valid <= 1'b0;

		// Drain, then allow for the pipeline depth.
		drain = 0;
		while (expected_q.size() != 0 && drain < 100_000) begin
			@(posedge clk);
			drain++;
		end
		repeat (LATENCY * 4) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (expected_q.size() != 0)
				$display("%0t: %0d result words never arrived", $time, expected_q.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
